@@ rtl/core/hjs_pkg.sv @@
// types, constants and helpers for the handwheel jog smoothing block
package hjs_pkg;

	localparam int NUM_AXES   = 4;
	localparam int FRAC_BITS  = 16;

	localparam int POS_W      = 32;
	localparam int TGT_W      = 48;
	localparam int COEF_W     = 16;
	localparam int SCALE_W    = 16;
	localparam int SETTLE_W   = 20;
	localparam int IDLE_W     = 21;
	localparam int AXIS_W     = 2;
	localparam int SEL_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int DIFF_W     = TGT_W + 1;
	localparam int MUL_A_W    = 34;
	localparam int MUL_B_W    = 18;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = 52;
	localparam int SUM_W      = 58;
	localparam int C_W        = COEF_W + 1;

	localparam logic [COEF_W-1:0]   COEFF_RST   = 16'd64754;
	localparam logic [SETTLE_W-1:0] SETTLE_RST  = 20'd11111;
	localparam logic [SCALE_W-1:0]  SCALE1_RST  = 16'd4;
	localparam logic [SCALE_W-1:0]  SCALE10_RST = 16'd20;
	localparam logic [SCALE_W-1:0]  SCALE100_RST = 16'd40;
	localparam logic [SCALE_W-1:0]  SCALE200_RST = 16'd400;
	localparam logic [IDLE_W-1:0]   IDLE_MAX    = {IDLE_W{1'b1}};

	localparam logic signed [TGT_W-1:0] TGT_MAX = {1'b0, {(TGT_W-1){1'b1}}};
	localparam logic signed [TGT_W-1:0] TGT_MIN = {1'b1, {(TGT_W-1){1'b0}}};

	localparam longint STEP_LIM = ((longint'(1) <<< (TGT_W-1)) - 1) >>> FRAC_BITS;
	localparam logic signed [PROD_W-1:0] STEP_HI = PROD_W'(STEP_LIM);
	localparam logic signed [PROD_W-1:0] STEP_LO = -STEP_HI;
	localparam logic signed [SUM_W-1:0]  STEP_FULL = SUM_W'(longint'(1) <<< TGT_W);

	localparam logic CMD_FINAL  = 1'b0;
	localparam logic CMD_SMOOTH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF1    = 3'd0,
		REG_COEFF2    = 3'd1,
		REG_SETTLE    = 3'd2,
		REG_SCALE_X1  = 3'd3,
		REG_SCALE_X10 = 3'd4,
		REG_SCALE_X100 = 3'd5,
		REG_SCALE_X200 = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_STEP_MUL,
		ST_STEP_ADD,
		ST_F_DIFF,
		ST_F_MHI,
		ST_F_MLO,
		ST_F_ADD,
		ST_EMIT
	} state_t;

	// clamp a wide intermediate to the signed target range
	function automatic logic signed [TGT_W-1:0] sat_tgt(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(TGT_MAX)) begin
			return TGT_MAX;
		end else if (v < SUM_W'(TGT_MIN)) begin
			return TGT_MIN;
		end else begin
			return v[TGT_W-1:0];
		end
	endfunction

endpackage

@@ rtl/core/handwheel_jog_smoothing.sv @@
// handwheel jog smoothing: jog step, two low-pass stages, move command output
//
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   encoder_position, wheel_enable, job_running,
//                                            factor_select, axis_select, dest_x..dest_a
// output    out        out_valid / out_stall command, axis, target, last
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// a slice with no motion and no encoder step ends at the finalize check; motion runs both
// filter stages, a step runs the jog step before them and, if it starts motion, a target
// load first; output stalls hold it; one shared 34 x 18 multiplier serves the jog step and
// both filter stages, up to five products per slice, one per cycle; in_stall is high from
// the cycle after a transaction until the slice's last result, if any, sits in the output
// register; reset clears control and slice state, loads the defaults; cfg_ready stays high
module handwheel_jog_smoothing (
	input  logic                                clk,
	input  logic                                arst_n,
	// input slices
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [hjs_pkg::POS_W-1:0]    encoder_position,
	input  logic                                wheel_enable,
	input  logic                                job_running,
	input  logic [hjs_pkg::SEL_W-1:0]           factor_select,
	input  logic [hjs_pkg::SEL_W-1:0]           axis_select,
	input  logic signed [hjs_pkg::POS_W-1:0]    dest_x,
	input  logic signed [hjs_pkg::POS_W-1:0]    dest_y,
	input  logic signed [hjs_pkg::POS_W-1:0]    dest_z,
	input  logic signed [hjs_pkg::POS_W-1:0]    dest_a,
	// move commands
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                command,
	output logic [hjs_pkg::AXIS_W-1:0]          axis,
	output logic signed [hjs_pkg::TGT_W-1:0]    target,
	output logic                                last,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hjs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hjs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// configuration registers
	logic [hjs_pkg::COEF_W-1:0]   coeff1_q, coeff2_q;
	logic [hjs_pkg::SETTLE_W-1:0] settle_q;
	logic [hjs_pkg::SCALE_W-1:0]  scale1_q, scale10_q, scale100_q, scale200_q;

	// slice state
	hjs_pkg::state_t state_q, state_d;
	logic                              started_q;
	logic [hjs_pkg::POS_W-1:0]         prev_count_q;
	logic [hjs_pkg::SCALE_W-1:0]       scale_now_q;
	logic [hjs_pkg::AXIS_W-1:0]        cur_axis_q, held_axis_q;
	logic                              held_valid_q;
	logic                              moving_q;
	logic [hjs_pkg::IDLE_W-1:0]        idle_q;
	logic signed [hjs_pkg::TGT_W-1:0]  raw_q, s1_q, smooth_q;
	logic                              stage_q;

	// per-slice working registers
	logic signed [hjs_pkg::POS_W-1:0]  delta_q, dest_q;
	logic signed [hjs_pkg::DIFF_W-1:0] diff_q;
	logic signed [hjs_pkg::PROD_W-1:0] prod_q;
	logic signed [hjs_pkg::ACC_W-1:0]  acc_q;

	// output register
	logic                              out_valid_q, cmd_q, last_q;
	logic [hjs_pkg::AXIS_W-1:0]        axis_q;
	logic signed [hjs_pkg::TGT_W-1:0]  target_q;

	logic accept, can_load;
	logic out_load, out_cmd_d, out_last_d;
	logic [hjs_pkg::AXIS_W-1:0]        out_axis_d;
	logic signed [hjs_pkg::TGT_W-1:0]  out_tgt_d;

	logic                              sel_found;
	logic [hjs_pkg::AXIS_W-1:0]        sel_idx, axis_new;
	logic signed [hjs_pkg::POS_W-1:0]  dest_new;
	logic [hjs_pkg::SCALE_W-1:0]       scale_sel;
	logic                              jog_on;

	logic [hjs_pkg::IDLE_W-1:0]        idle_next;
	logic                              fin, delta_nz, moving_after, chk_go;

	logic signed [hjs_pkg::TGT_W-1:0]  flt_x, flt_y, flt_new;
	logic [hjs_pkg::COEF_W-1:0]        flt_k;
	logic [hjs_pkg::C_W-1:0]           flt_c;

	logic signed [hjs_pkg::MUL_A_W-1:0] mul_a;
	logic signed [hjs_pkg::MUL_B_W-1:0] mul_b;
	logic signed [hjs_pkg::PROD_W-1:0]  mul_p;

	logic signed [hjs_pkg::SUM_W-1:0]   stepv, dest_wide;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != hjs_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign can_load  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign command   = cmd_q;
	assign axis      = axis_q;
	assign target    = target_q;
	assign last      = last_q;

	// lowest set axis bit; no set bit keeps the current axis
	always_comb begin
		sel_found = 1'b0;
		sel_idx   = '0;
		for (int i = hjs_pkg::SEL_W - 1; i >= 0; i--) begin
			if (axis_select[i]) begin
				sel_found = 1'b1;
				sel_idx   = hjs_pkg::AXIS_W'(i);
			end
		end
		axis_new = (sel_found && (int'(sel_idx) < hjs_pkg::NUM_AXES)) ? sel_idx : cur_axis_q;
		case (axis_new)
			2'd0:    dest_new = dest_x;
			2'd1:    dest_new = dest_y;
			2'd2:    dest_new = dest_z;
			2'd3:    dest_new = dest_a;
			default: dest_new = dest_x;
		endcase
	end

	// jog factor, lowest set bit wins
	always_comb begin
		if (factor_select[0]) begin
			scale_sel = scale1_q;
		end else if (factor_select[1]) begin
			scale_sel = scale10_q;
		end else if (factor_select[2]) begin
			scale_sel = scale100_q;
		end else if (factor_select[3]) begin
			scale_sel = scale200_q;
		end else begin
			scale_sel = '0;
		end
	end

	assign jog_on = wheel_enable && !job_running;

	// finalize decision
	assign idle_next = (moving_q && (idle_q != hjs_pkg::IDLE_MAX)) ?
		idle_q + hjs_pkg::IDLE_W'(1) : idle_q;
	assign fin = !held_valid_q || (cur_axis_q != held_axis_q) ||
		(moving_q && (idle_next > hjs_pkg::IDLE_W'(settle_q)));
	assign delta_nz     = (delta_q != '0);
	assign moving_after = moving_q && !fin;
	assign chk_go       = !(fin && moving_q) || can_load;

	// filter stage operands: stage 0 chases the raw target, stage 1 chases stage 0
	always_comb begin
		if (!stage_q) begin
			flt_x = raw_q;
			flt_y = s1_q;
			flt_k = coeff1_q;
		end else begin
			flt_x = s1_q;
			flt_y = smooth_q;
			flt_k = coeff2_q;
		end
		flt_c   = hjs_pkg::C_W'(1 << hjs_pkg::COEF_W) - hjs_pkg::C_W'(flt_k);
		flt_new = hjs_pkg::TGT_W'(acc_q + (prod_q >>> hjs_pkg::COEF_W));
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			hjs_pkg::ST_STEP_MUL: begin
				mul_a = hjs_pkg::MUL_A_W'(delta_q);
				mul_b = $signed({2'b00, scale_now_q});
			end
			hjs_pkg::ST_F_MHI: begin
				mul_a = hjs_pkg::MUL_A_W'($signed(diff_q[hjs_pkg::DIFF_W-1:hjs_pkg::COEF_W]));
				mul_b = $signed({1'b0, flt_c});
			end
			hjs_pkg::ST_F_MLO: begin
				mul_a = $signed({{(hjs_pkg::MUL_A_W-hjs_pkg::COEF_W){1'b0}},
					diff_q[hjs_pkg::COEF_W-1:0]});
				mul_b = $signed({1'b0, flt_c});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// jog step, clamped to a full-range move
	always_comb begin
		if (prod_q > hjs_pkg::STEP_HI) begin
			stepv = hjs_pkg::STEP_FULL;
		end else if (prod_q < hjs_pkg::STEP_LO) begin
			stepv = -hjs_pkg::STEP_FULL;
		end else begin
			stepv = hjs_pkg::SUM_W'(prod_q) <<< hjs_pkg::FRAC_BITS;
		end
		dest_wide = hjs_pkg::SUM_W'(dest_q) <<< hjs_pkg::FRAC_BITS;
	end

	// sequencer: next state and result loads
	always_comb begin
		state_d    = state_q;
		out_load   = 1'b0;
		out_cmd_d  = hjs_pkg::CMD_SMOOTH;
		out_axis_d = cur_axis_q;
		out_tgt_d  = smooth_q;
		out_last_d = 1'b1;
		case (state_q)
			hjs_pkg::ST_IDLE: begin
				if (accept) state_d = hjs_pkg::ST_CHECK;
			end
			hjs_pkg::ST_CHECK: begin
				if (chk_go) begin
					if (fin && moving_q) begin
						out_load   = 1'b1;
						out_cmd_d  = hjs_pkg::CMD_FINAL;
						out_axis_d = held_axis_q;
						out_last_d = !delta_nz;
					end
					if (delta_nz) begin
						state_d = moving_after ? hjs_pkg::ST_STEP_MUL : hjs_pkg::ST_LOAD;
					end else if (moving_after) begin
						state_d = hjs_pkg::ST_F_DIFF;
					end else begin
						state_d = hjs_pkg::ST_IDLE;
					end
				end
			end
			hjs_pkg::ST_LOAD:     state_d = hjs_pkg::ST_STEP_MUL;
			hjs_pkg::ST_STEP_MUL: state_d = hjs_pkg::ST_STEP_ADD;
			hjs_pkg::ST_STEP_ADD: state_d = hjs_pkg::ST_F_DIFF;
			hjs_pkg::ST_F_DIFF:   state_d = hjs_pkg::ST_F_MHI;
			hjs_pkg::ST_F_MHI:    state_d = hjs_pkg::ST_F_MLO;
			hjs_pkg::ST_F_MLO:    state_d = hjs_pkg::ST_F_ADD;
			hjs_pkg::ST_F_ADD: begin
				state_d = stage_q ? hjs_pkg::ST_EMIT : hjs_pkg::ST_F_DIFF;
			end
			hjs_pkg::ST_EMIT: begin
				if (can_load) begin
					out_load = 1'b1;
					state_d  = hjs_pkg::ST_IDLE;
				end
			end
			default: state_d = hjs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hjs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff1_q   <= hjs_pkg::COEFF_RST;
			coeff2_q   <= hjs_pkg::COEFF_RST;
			settle_q   <= hjs_pkg::SETTLE_RST;
			scale1_q   <= hjs_pkg::SCALE1_RST;
			scale10_q  <= hjs_pkg::SCALE10_RST;
			scale100_q <= hjs_pkg::SCALE100_RST;
			scale200_q <= hjs_pkg::SCALE200_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hjs_pkg::REG_COEFF1:     coeff1_q   <= cfg_data[hjs_pkg::COEF_W-1:0];
				hjs_pkg::REG_COEFF2:     coeff2_q   <= cfg_data[hjs_pkg::COEF_W-1:0];
				hjs_pkg::REG_SETTLE:     settle_q   <= cfg_data[hjs_pkg::SETTLE_W-1:0];
				hjs_pkg::REG_SCALE_X1:   scale1_q   <= cfg_data[hjs_pkg::SCALE_W-1:0];
				hjs_pkg::REG_SCALE_X10:  scale10_q  <= cfg_data[hjs_pkg::SCALE_W-1:0];
				hjs_pkg::REG_SCALE_X100: scale100_q <= cfg_data[hjs_pkg::SCALE_W-1:0];
				hjs_pkg::REG_SCALE_X200: scale200_q <= cfg_data[hjs_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// slice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			prev_count_q <= '0;
			scale_now_q  <= '0;
			cur_axis_q   <= '0;
			held_axis_q  <= '0;
			held_valid_q <= 1'b0;
			moving_q     <= 1'b0;
			idle_q       <= '0;
			raw_q        <= '0;
			s1_q         <= '0;
			smooth_q     <= '0;
			stage_q      <= 1'b0;
		end else begin
			case (state_q)
				hjs_pkg::ST_IDLE: begin
					if (accept) begin
						started_q    <= 1'b1;
						prev_count_q <= encoder_position;
						cur_axis_q   <= axis_new;
						if (jog_on) scale_now_q <= scale_sel;
					end
				end
				hjs_pkg::ST_CHECK: begin
					if (chk_go) begin
						idle_q  <= idle_next;
						stage_q <= 1'b0;
						if (fin) begin
							held_axis_q  <= cur_axis_q;
							held_valid_q <= 1'b1;
							moving_q     <= 1'b0;
						end
					end
				end
				hjs_pkg::ST_LOAD: begin
					raw_q    <= hjs_pkg::sat_tgt(dest_wide);
					s1_q     <= hjs_pkg::sat_tgt(dest_wide);
					smooth_q <= hjs_pkg::sat_tgt(dest_wide);
				end
				hjs_pkg::ST_STEP_ADD: begin
					raw_q    <= hjs_pkg::sat_tgt(hjs_pkg::SUM_W'(raw_q) + stepv);
					idle_q   <= '0;
					moving_q <= 1'b1;
				end
				hjs_pkg::ST_F_ADD: begin
					if (!stage_q) begin
						s1_q <= flt_new;
					end else begin
						smooth_q <= flt_new;
					end
					stage_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= (started_q && jog_on) ? (encoder_position - $signed(prev_count_q)) : '0;
			dest_q  <= dest_new;
		end
		if (state_q == hjs_pkg::ST_F_DIFF) begin
			diff_q <= hjs_pkg::DIFF_W'(flt_x) - hjs_pkg::DIFF_W'(flt_y);
		end
		if (state_q == hjs_pkg::ST_STEP_MUL || state_q == hjs_pkg::ST_F_MHI ||
			state_q == hjs_pkg::ST_F_MLO) begin
			prod_q <= mul_p;
		end
		if (state_q == hjs_pkg::ST_F_MLO) begin
			acc_q <= hjs_pkg::ACC_W'(flt_y) + prod_q;
		end
		if (out_load) begin
			cmd_q    <= out_cmd_d;
			axis_q   <= out_axis_d;
			target_q <= out_tgt_d;
			last_q   <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == hjs_pkg::ST_CHECK)
		else $error("slice transaction not followed by the finalize check");

	a_moving_held: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> held_valid_q)
		else $error("motion without a held axis");

	a_emit_moving: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hjs_pkg::ST_EMIT |-> moving_q)
		else $error("smooth move issued while not moving");

	a_smooth_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_cmd_d == hjs_pkg::CMD_SMOOTH |-> out_last_d)
		else $error("smooth move not marked last");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> can_load)
		else $error("output register overwritten while stalled");
`endif

endmodule
